// ===== rtl/core/mpfl_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-pool free list allocator package
// Shared types, operation codes and sizing constants for the allocator.
// ----------------------------------------------------------------------------
package mpfl_pkg;

	// Fixed field widths of the command and response transactions.
	localparam int FUNC_W      = 2;
	localparam int POOL_W      = 2;
	localparam int HANDLE_W    = 8;
	localparam int LINK_W      = HANDLE_W + 1;
	localparam int LINK_DEPTH  = 1 << HANDLE_W;
	localparam int COUNT_W     = 7;
	localparam int NUM_REGS    = 4;
	localparam int CFG_INDEX_W = 2;

	// Link value with the top bit set marks the end of a list.
	localparam logic [LINK_W-1:0] EMPTY_MARK = {1'b1, {HANDLE_W{1'b0}}};

	// Reset value of every pool count register.
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

	// Defaults for the top level parameters.
	localparam int NUM_POOLS_DEF  = 4;
	localparam int POOL_SLOTS_DEF = 64;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [POOL_W-1:0]   pool;
		logic [HANDLE_W-1:0] handle;
		logic                handle_null;
	} cmd_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] got_handle;
		logic                ok;
	} rsp_t;

endpackage

// ===== rtl/core/mpfl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mpfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/multi_pool_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// Multi-pool free list allocator
// One last-in-first-out free list per pool over a shared next-link RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Transaction taken when
//  --------  -----------------------------  -----------------------------
//  command   start, busy, cmd               start high and busy low
//  response  done, result                   done high (one cycle, no stall)
//  config    cfg_we, cfg_index, cfg_data    cfg_we high
//
// A free, a null free or a rejected command answers in the cycle after it
// is taken; a pop answers from the ALLOC state, after the registered link
// RAM read. Init fills each pool with its clamped count of links, one link
// per cycle, sets its head, and answers once the last pool is done.
// Reset empties every list and sets the counts to sixteen; the link RAM
// holds nothing until init or free writes it. The receiver cannot stall.
//
module multi_pool_free_list_allocator
	import mpfl_pkg::*;
#(
	parameter int NUM_POOLS  = NUM_POOLS_DEF,
	parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  cmd_t                   cmd,
	output logic                   done,
	output rsp_t                   result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]     cfg_data
);

	localparam int PIDX_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int BASE_W = $clog2(NUM_POOLS * POOL_SLOTS) + 1;
	localparam int CALC_W = (BASE_W > 11) ? BASE_W : 11;
	localparam int SLOT_W = HANDLE_W + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_INIT  = 2'd2;

	logic [1:0]          state_q;
	logic [LINK_W-1:0]   head_q [NUM_POOLS];
	logic [COUNT_W-1:0]  count_q [NUM_REGS];
	logic                done_q;
	rsp_t                rsp_q;
	logic [POOL_W-1:0]   pool_s1;
	logic [HANDLE_W-1:0] got_s1;
	logic [PIDX_W-1:0]   pool_q;
	logic [BASE_W-1:0]   base_q;
	logic [SLOT_W-1:0]   slot_q;

	logic                accept;
	logic                pool_in_range;
	logic [LINK_W-1:0]   head_sel;
	logic [COUNT_W-1:0]  cnt_raw;
	logic [CALC_W-1:0]   cnt_calc;
	logic [CALC_W-1:0]   base_wide;
	logic [CALC_W-1:0]   room;
	logic [SLOT_W-1:0]   cnt_eff;
	logic                init_fill;
	logic [HANDLE_W-1:0] init_addr;
	logic [LINK_W-1:0]   init_head;
	logic                ram_we;
	logic [HANDLE_W-1:0] ram_waddr;
	logic [LINK_W-1:0]   ram_wdata;
	logic [LINK_W-1:0]   ram_rdata;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = rsp_q;

	// Head of the addressed pool.
	always_comb begin
		head_sel = EMPTY_MARK;
		for (int i = 0; i < NUM_POOLS; i++) begin
			if (int'(cmd.pool) == i) begin
				head_sel = head_q[i];
			end
		end
		pool_in_range = (int'(cmd.pool) < NUM_POOLS);
	end

	// Number of elements carved into the pool that init is building.
	always_comb begin
		cnt_raw = '0;
		for (int i = 0; i < NUM_REGS; i++) begin
			if (int'(pool_q) == i) begin
				cnt_raw = count_q[i];
			end
		end
		cnt_calc  = CALC_W'(cnt_raw);
		base_wide = CALC_W'(base_q);
		if (cnt_calc > CALC_W'(POOL_SLOTS)) begin
			cnt_calc = CALC_W'(POOL_SLOTS);
		end
		room = '0;
		if (base_wide < CALC_W'(LINK_DEPTH)) begin
			room = CALC_W'(LINK_DEPTH) - base_wide;
		end
		if (cnt_calc > room) begin
			cnt_calc = room;
		end
		cnt_eff = cnt_calc[SLOT_W-1:0];
	end

	// Init writes one link per cycle while filling a pool; the new head is the last element carved.
	assign init_fill = (state_q == ST_INIT) && (slot_q < cnt_eff);
	assign init_addr = base_q[HANDLE_W-1:0] + slot_q[HANDLE_W-1:0];
	assign init_head = (cnt_eff == '0) ? EMPTY_MARK :
		{1'b0, base_q[HANDLE_W-1:0] + cnt_eff[HANDLE_W-1:0] - HANDLE_W'(1)};

	// Link RAM write port: init sweep or a free push.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cmd.handle;
		ram_wdata = head_sel;
		if (init_fill) begin
			ram_we    = 1'b1;
			ram_waddr = init_addr;
			ram_wdata = (slot_q == '0) ? EMPTY_MARK : {1'b0, init_addr - HANDLE_W'(1)};
		end else if (accept && cmd.func == FUNC_FREE && !cmd.handle_null && pool_in_range) begin
			ram_we = 1'b1;
		end
	end

	mpfl_ram #(
		.WIDTH (LINK_W),
		.DEPTH (LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_sel[HANDLE_W-1:0]),
		.rdata (ram_rdata)
	);

	// Count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				count_q[i] <= COUNT_RESET;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (int'(cfg_index) == i) begin
					count_q[i] <= cfg_data;
				end
			end
		end
	end

	// Command sequencer, pool heads and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			rsp_q   <= '0;
			pool_s1 <= '0;
			got_s1  <= '0;
			pool_q  <= '0;
			base_q  <= '0;
			slot_q  <= '0;
			for (int i = 0; i < NUM_POOLS; i++) begin
				head_q[i] <= EMPTY_MARK;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.func)
							FUNC_ALLOC: begin
								if (pool_in_range && !head_sel[HANDLE_W]) begin
									state_q <= ST_ALLOC;
									pool_s1 <= cmd.pool;
									got_s1  <= head_sel[HANDLE_W-1:0];
								end else begin
									done_q <= 1'b1;
									rsp_q  <= '0;
								end
							end
							FUNC_FREE: begin
								done_q     <= 1'b1;
								rsp_q.got_handle <= '0;
								rsp_q.ok   <= cmd.handle_null || pool_in_range;
								if (!cmd.handle_null) begin
									for (int i = 0; i < NUM_POOLS; i++) begin
										if (int'(cmd.pool) == i) begin
											head_q[i] <= {1'b0, cmd.handle};
										end
									end
								end
							end
							FUNC_INIT: begin
								state_q <= ST_INIT;
								pool_q  <= '0;
								base_q  <= '0;
								slot_q  <= '0;
							end
							default: begin
								done_q <= 1'b1;
								rsp_q  <= '0;
							end
						endcase
					end
				end
				ST_ALLOC: begin
					// The popped element's link becomes the new head.
					for (int i = 0; i < NUM_POOLS; i++) begin
						if (int'(pool_s1) == i) begin
							head_q[i] <= ram_rdata;
						end
					end
					done_q           <= 1'b1;
					rsp_q.got_handle <= got_s1;
					rsp_q.ok         <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_INIT: begin
					if (init_fill) begin
						slot_q <= slot_q + SLOT_W'(1);
					end else begin
						head_q[pool_q] <= init_head;
						slot_q         <= '0;
						base_q         <= base_q + BASE_W'(POOL_SLOTS);
						if (pool_q == PIDX_W'(NUM_POOLS - 1)) begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
							rsp_q.got_handle <= '0;
							rsp_q.ok         <= 1'b1;
						end else begin
							pool_q <= pool_q + PIDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A pop always answers in the cycle after the link read.
	a_alloc_answers: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALLOC |=> done && result.ok)
		else $error("alloc did not answer after the link read");

	// A failed transaction never carries a handle.
	a_fail_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.ok |-> result.got_handle == '0)
		else $error("failed transaction carries a handle");

	// The link RAM is not written while a pop waits for its read data.
	a_no_write_in_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALLOC |-> !ram_we)
		else $error("link RAM written during a pop");

	// An accepted init holds the command channel off.
	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.func == FUNC_INIT |=> busy && !done)
		else $error("init did not start its sweep");

	// No response while a sweep is still writing links.
	a_no_done_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		init_fill |=> !done)
		else $error("response issued during the init sweep");

endmodule

// ===== sim/mpfl_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-pool free list allocator checker
// Watches the command, response and configuration channels, keeps its own
// copy of every free list, and compares each response against the oldest
// predicted one. Mismatches are printed and counted for the testbench top.
// ----------------------------------------------------------------------------
module mpfl_checker
	import mpfl_pkg::*;
#(
	parameter int NUM_POOLS  = NUM_POOLS_DEF,
	parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  cmd_t                   cmd,
	input  logic                   done,
	input  rsp_t                   result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]     cfg_data,
	input  logic                   drained,
	output int                     fail_count
);

	// Predicted state of the allocator.
	logic [COUNT_W-1:0] count_q [NUM_REGS];
	logic [LINK_W-1:0]  head_q  [NUM_POOLS];
	logic [LINK_W-1:0]  link_q  [LINK_DEPTH];

	// Responses predicted but not yet seen.
	rsp_t expected_rsp_q [$];
	rsp_t want_rsp;
	int   mismatch_total = 0;
	bit   drain_checked  = 1'b0;

	assign fail_count = mismatch_total;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: response mismatch: %s", $time, msg);
		mismatch_total++;
	endtask

	// Rebuild every free list from the current counts, clamped to the pool
	// size and to the end of the link store.
	function automatic void rebuild_free_lists();
		int                base;
		int                cnt;
		logic [LINK_W-1:0] head;
		for (int p = 0; p < NUM_POOLS; p++) begin
			base = p * POOL_SLOTS;
			cnt  = (p < NUM_REGS) ? int'(count_q[p]) : 0;
			head = EMPTY_MARK;
			if (cnt > POOL_SLOTS)
				cnt = POOL_SLOTS;
			if (base >= LINK_DEPTH)
				cnt = 0;
			else if (cnt > LINK_DEPTH - base)
				cnt = LINK_DEPTH - base;
			for (int j = 0; j < cnt; j++) begin
				link_q[base + j] = head;
				head = LINK_W'(base + j);
			end
			head_q[p] = head;
		end
	endfunction

	// Apply one command to the predicted state and return its response.
	function automatic rsp_t apply_command(input cmd_t c);
		rsp_t r;
		r = '0;
		case (c.func)
			FUNC_ALLOC: begin
				if (int'(c.pool) < NUM_POOLS && !head_q[c.pool][HANDLE_W]) begin
					r.got_handle = head_q[c.pool][HANDLE_W-1:0];
					r.ok = 1'b1;
					head_q[c.pool] = link_q[r.got_handle];
				end
			end
			FUNC_FREE: begin
				if (c.handle_null) begin
					r.ok = 1'b1;
				end else if (int'(c.pool) < NUM_POOLS) begin
					link_q[c.handle] = head_q[c.pool];
					head_q[c.pool] = {1'b0, c.handle};
					r.ok = 1'b1;
				end
			end
			FUNC_INIT: begin
				rebuild_free_lists();
				r.ok = 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Track configuration and commands, then check responses in order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (count_q[i])
				count_q[i] = COUNT_RESET;
			foreach (head_q[i])
				head_q[i] = EMPTY_MARK;
			foreach (link_q[i])
				link_q[i] = '0;
			expected_rsp_q.delete();
		end else begin
			if (cfg_we && int'(cfg_index) < NUM_REGS)
				count_q[cfg_index] = cfg_data;
			if (start && !busy)
				expected_rsp_q.push_back(apply_command(cmd));
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("response with no command outstanding");
				end else begin
					want_rsp = expected_rsp_q.pop_front();
					if (result.got_handle !== want_rsp.got_handle)
						report_mismatch($sformatf("got_handle %0d, expected %0d",
							result.got_handle, want_rsp.got_handle));
					if (result.ok !== want_rsp.ok)
						report_mismatch($sformatf("ok %0b, expected %0b",
							result.ok, want_rsp.ok));
				end
			end
			// Anything still waiting once the run has drained never arrived.
			if (drained && !drain_checked) begin
				drain_checked = 1'b1;
				foreach (expected_rsp_q[i])
					report_mismatch("expected response never arrived");
				expected_rsp_q.delete();
			end
		end
	end

endmodule

// ===== sim/tb_multi_pool_free_list_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-pool free list allocator testbench
// Drives a short directed sequence covering empty pools, null, foreign and
// double frees, unused operations and clamped counts, then phases of random
// allocate and free traffic under several count settings. A checker module
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_multi_pool_free_list_allocator;
	import mpfl_pkg::*;

	localparam int NUM_POOLS  = NUM_POOLS_DEF;
	localparam int POOL_SLOTS = POOL_SLOTS_DEF;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	cmd_t                   cmd;
	logic                   done;
	rsp_t                   result;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [COUNT_W-1:0]     cfg_data;
	logic                   drained;
	int                     fail_count;

	// Transaction counters and handles currently held by the stimulus.
	int                  sent_total = 0;
	int                  answered_total;
	logic [HANDLE_W-1:0] live_handles [$];
	bit                  burst = 1'b0;

	multi_pool_free_list_allocator #(
		.NUM_POOLS  (NUM_POOLS),
		.POOL_SLOTS (POOL_SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mpfl_checker #(
		.NUM_POOLS  (NUM_POOLS),
		.POOL_SLOTS (POOL_SLOTS)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.drained    (drained),
		.fail_count (fail_count)
	);

	// 100 MHz clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count responses as they arrive.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			answered_total <= 0;
		else if (done)
			answered_total <= answered_total + 1;
	end

	// Remember handles handed out so that later frees return them.
	always @(negedge clk) begin
		if (arst_n && done && result.ok && result.got_handle != '0)
			live_handles.push_back(result.got_handle);
	end

	function automatic cmd_t make_cmd(input logic [FUNC_W-1:0] func,
			input int pool, input int handle, input bit is_null);
		cmd_t c;
		c.func        = func;
		c.pool        = POOL_W'(pool);
		c.handle      = HANDLE_W'(handle);
		c.handle_null = is_null;
		return c;
	endfunction

	// Mostly allocations and frees of held handles, with some null, foreign
	// and double frees, re-inits and unused operations mixed in.
	function automatic cmd_t random_command();
		cmd_t c;
		int   pick;
		int   sub;
		int   slot;
		c.func        = FUNC_ALLOC;
		c.pool        = POOL_W'($urandom);
		c.handle      = HANDLE_W'($urandom);
		c.handle_null = 1'b0;
		pick = $urandom_range(0, 99);
		if (pick < 85 && pick >= 48) begin
			c.func = FUNC_FREE;
			sub = $urandom_range(0, 19);
			if (sub < 2) begin
				c.handle_null = 1'b1;
			end else if (sub < 18 && live_handles.size() > 0) begin
				slot = $urandom_range(0, live_handles.size() - 1);
				c.handle = live_handles[slot];
				// A few frees leave the handle held, giving double frees later.
				if (sub < 16)
					live_handles.delete(slot);
				if ($urandom_range(0, 9) != 0)
					c.pool = POOL_W'(int'(c.handle) / POOL_SLOTS);
			end
		end else if (pick >= 85 && pick < 91) begin
			c.func = FUNC_INIT;
		end else if (pick >= 91 && pick < 95) begin
			c.func = FUNC_NONE;
		end
		return c;
	endfunction

	// Offer one command, hold it until taken, then, outside a burst, idle for a random gap.
	task automatic send(input cmd_t c);
		int gap;
		start <= 1'b1;
		cmd   <= c;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		sent_total++;
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering commands and wait for every response and for the block
	// to go idle.
	task automatic wait_idle();
		start <= 1'b0;
		@(negedge clk);
		while (answered_total != sent_total || busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Write all pool counts back to back; called only while idle.
	task automatic program_counts(input logic [NUM_REGS-1:0][COUNT_W-1:0] counts);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_INDEX_W'(i);
			cfg_data  <= counts[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [NUM_REGS-1:0][COUNT_W-1:0] counts;
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		drained   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Before any init: empty pools, null free, unused code, and a free
		// that builds a one-element list by hand.
		send(make_cmd(FUNC_ALLOC, 0, 0, 1'b0));
		send(make_cmd(FUNC_FREE, 1, 77, 1'b1));
		send(make_cmd(FUNC_NONE, 3, 255, 1'b1));
		send(make_cmd(FUNC_FREE, 2, 5, 1'b0));
		send(make_cmd(FUNC_ALLOC, 2, 0, 1'b0));
		send(make_cmd(FUNC_ALLOC, 2, 0, 1'b0));

		// Reset counts, then foreign and double frees.
		send(make_cmd(FUNC_INIT, 0, 0, 1'b0));
		send(make_cmd(FUNC_ALLOC, 0, 0, 1'b0));
		send(make_cmd(FUNC_ALLOC, 3, 0, 1'b0));
		send(make_cmd(FUNC_FREE, 1, 255, 1'b0));
		send(make_cmd(FUNC_ALLOC, 1, 0, 1'b0));
		send(make_cmd(FUNC_FREE, 0, 0, 1'b0));
		send(make_cmd(FUNC_FREE, 0, 0, 1'b0));
		send(make_cmd(FUNC_ALLOC, 0, 0, 1'b0));
		send(make_cmd(FUNC_ALLOC, 0, 0, 1'b0));
		send(make_cmd(FUNC_FREE, 3, 255, 1'b1));

		// Full, empty, oversized and single-element pools.
		wait_idle();
		counts = {COUNT_W'(1), COUNT_W'(127), COUNT_W'(0), COUNT_W'(64)};
		program_counts(counts);
		send(make_cmd(FUNC_INIT, 0, 0, 1'b0));
		send(make_cmd(FUNC_ALLOC, 1, 0, 1'b0));
		send(make_cmd(FUNC_ALLOC, 2, 0, 1'b0));
		send(make_cmd(FUNC_ALLOC, 3, 0, 1'b0));
		send(make_cmd(FUNC_ALLOC, 3, 0, 1'b0));
		send(make_cmd(FUNC_ALLOC, 0, 0, 1'b0));

		// Random phases, each under its own count setting.
		for (int phase = 0; phase < 8; phase++) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				case (phase)
					0: counts[i] = COUNT_W'(64);
					1: counts[i] = '0;
					2: counts[i] = '1;
					3: counts[i] = COUNT_W'(1);
					default: counts[i] = ($urandom_range(0, 7) == 0) ?
						COUNT_W'($urandom_range(0, 127)) : COUNT_W'($urandom_range(0, 64));
				endcase
			end
			wait_idle();
			program_counts(counts);
			live_handles.delete();
			send(make_cmd(FUNC_INIT, 0, 0, 1'b0));
			for (int n = 0; n < 112; n++) begin
				if (n % 16 == 0)
					burst = ($urandom_range(0, 3) == 0);
				send(random_command());
			end
			burst = 1'b0;
		end

		// Drain, allow for a trailing list rebuild, then give the verdict.
		wait_idle();
		repeat (300) @(posedge clk);
		drained <= 1'b1;
		repeat (3) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== multi_pool_free_list_allocator.f =====
rtl/core/mpfl_pkg.sv
rtl/core/mpfl_ram.sv
rtl/core/multi_pool_free_list_allocator.sv
sim/mpfl_checker.sv
sim/tb_multi_pool_free_list_allocator.sv
